### rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the buddy allocator controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package bba_pkg;

  localparam int NumBlocks = 256;
  localparam int Levels    = 9;
  localparam int BlkW      = 8;
  localparam int CntW      = 9;
  localparam int LvW       = 4;
  localparam int StepW     = 9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT_CLR,
    CMD_INIT_NEXT,
    CMD_LOAD,
    CMD_FREE_SET,
    CMD_SCAN,
    CMD_NOFREE,
    CMD_POP,
    CMD_POP_WR,
    CMD_SPLIT,
    CMD_REL_START,
    CMD_WALK_RD,
    CMD_WALK_ADV,
    CMD_UNLINK,
    CMD_CLR_CUR,
    CMD_PUSH
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic init_done;
    logic bad;
    logic op;
    logic s_over;
    logic head_s_zero;
    logic s_gt_lv;
    logic rlv_top;
    logic walk_end;
    logic cur_hit;
    logic out_busy;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_CLR,
    S_INIT_CHK,
    S_CHK,
    S_SCAN,
    S_POP,
    S_POP_WR,
    S_SPLIT_CHK,
    S_REL_START,
    S_WALK_CHK,
    S_WALK_ADV,
    S_HIT_RD,
    S_UNLINK,
    S_CLR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    CTX_INIT,
    CTX_ALLOC,
    CTX_FREE
  } ctx_t;

endpackage
`default_nettype wire

### rtl/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// Sequencer for rebuild, allocate, split, buddy search, merge and push.
// ---------------------------------------------------------------------------
`default_nettype none
module bba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  bba_pkg::stat_t      stat,
  output bba_pkg::ctl_t       ctl
);

  bba_pkg::state_t state, state_next;
  bba_pkg::ctx_t   ctx, ctx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_INIT_CLR;
      ctx   <= bba_pkg::CTX_INIT;
    end else if (cfg_we) begin
      state <= bba_pkg::S_INIT_CLR;
      ctx   <= bba_pkg::CTX_INIT;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    ctl.cmd    = bba_pkg::CMD_NONE;
    ctl.finish = 1'b0;
    in_ready   = 1'b0;
    case (state)
      bba_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          ctl.cmd    = bba_pkg::CMD_LOAD;
          state_next = bba_pkg::S_CHK;
        end
      end
      bba_pkg::S_INIT_CLR: begin
        ctl.cmd    = bba_pkg::CMD_INIT_CLR;
        ctx_next   = bba_pkg::CTX_INIT;
        state_next = bba_pkg::S_INIT_CHK;
      end
      bba_pkg::S_INIT_CHK: begin
        if (stat.init_done) begin
          state_next = bba_pkg::S_IDLE;
        end else begin
          ctl.cmd    = bba_pkg::CMD_INIT_NEXT;
          state_next = bba_pkg::S_REL_START;
        end
      end
      bba_pkg::S_CHK: begin
        if (stat.bad) begin
          state_next = bba_pkg::S_FINISH;
        end else if (stat.op == bba_pkg::OP_ALLOC) begin
          ctx_next   = bba_pkg::CTX_ALLOC;
          state_next = bba_pkg::S_SCAN;
        end else begin
          ctl.cmd    = bba_pkg::CMD_FREE_SET;
          ctx_next   = bba_pkg::CTX_FREE;
          state_next = bba_pkg::S_REL_START;
        end
      end
      bba_pkg::S_SCAN: begin
        if (stat.s_over) begin
          ctl.cmd    = bba_pkg::CMD_NOFREE;
          state_next = bba_pkg::S_FINISH;
        end else if (stat.head_s_zero) begin
          ctl.cmd = bba_pkg::CMD_SCAN;
        end else begin
          state_next = bba_pkg::S_POP;
        end
      end
      bba_pkg::S_POP: begin
        ctl.cmd    = bba_pkg::CMD_POP;
        state_next = bba_pkg::S_POP_WR;
      end
      bba_pkg::S_POP_WR: begin
        ctl.cmd    = bba_pkg::CMD_POP_WR;
        state_next = bba_pkg::S_SPLIT_CHK;
      end
      bba_pkg::S_SPLIT_CHK: begin
        if (stat.s_gt_lv) begin
          ctl.cmd    = bba_pkg::CMD_SPLIT;
          state_next = bba_pkg::S_REL_START;
        end else begin
          state_next = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_REL_START: begin
        if (stat.rlv_top) begin
          ctl.cmd = bba_pkg::CMD_PUSH;
          case (ctx)
            bba_pkg::CTX_INIT:  state_next = bba_pkg::S_INIT_CHK;
            bba_pkg::CTX_ALLOC: state_next = bba_pkg::S_SPLIT_CHK;
            default:            state_next = bba_pkg::S_FINISH;
          endcase
        end else begin
          ctl.cmd    = bba_pkg::CMD_REL_START;
          state_next = bba_pkg::S_WALK_CHK;
        end
      end
      bba_pkg::S_WALK_CHK: begin
        if (stat.walk_end) begin
          ctl.cmd = bba_pkg::CMD_PUSH;
          case (ctx)
            bba_pkg::CTX_INIT:  state_next = bba_pkg::S_INIT_CHK;
            bba_pkg::CTX_ALLOC: state_next = bba_pkg::S_SPLIT_CHK;
            default:            state_next = bba_pkg::S_FINISH;
          endcase
        end else if (stat.cur_hit) begin
          state_next = bba_pkg::S_HIT_RD;
        end else begin
          ctl.cmd    = bba_pkg::CMD_WALK_RD;
          state_next = bba_pkg::S_WALK_ADV;
        end
      end
      bba_pkg::S_WALK_ADV: begin
        ctl.cmd    = bba_pkg::CMD_WALK_ADV;
        state_next = bba_pkg::S_WALK_CHK;
      end
      bba_pkg::S_HIT_RD: begin
        ctl.cmd    = bba_pkg::CMD_WALK_RD;
        state_next = bba_pkg::S_UNLINK;
      end
      bba_pkg::S_UNLINK: begin
        ctl.cmd    = bba_pkg::CMD_UNLINK;
        state_next = bba_pkg::S_CLR;
      end
      bba_pkg::S_CLR: begin
        ctl.cmd    = bba_pkg::CMD_CLR_CUR;
        state_next = bba_pkg::S_REL_START;
      end
      bba_pkg::S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = bba_pkg::S_IDLE;
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/bba_datapath.sv
// ---------------------------------------------------------------------------
// bba_datapath
// Free list heads, link memory, walk registers and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module bba_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [bba_pkg::CntW-1:0]   cfg_data,
  output logic [bba_pkg::CntW-1:0]        total_blocks,
  input  wire logic                       in_op,
  input  wire logic [bba_pkg::BlkW-1:0]   in_index,
  input  wire logic [bba_pkg::CntW-1:0]   in_count,
  input  bba_pkg::ctl_t                   ctl,
  output bba_pkg::stat_t                  stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [bba_pkg::BlkW-1:0]        out_result
);

  localparam int BlkW = bba_pkg::BlkW;
  localparam int LvW  = bba_pkg::LvW;

  logic [BlkW-1:0] link_mem [bba_pkg::NumBlocks];
  logic [BlkW-1:0] head [bba_pkg::Levels];
  logic [BlkW-1:0] rdata;

  logic                    op;
  logic [LvW-1:0]          lv, s, rlv;
  logic [BlkW-1:0]         b, rb, cur, prev;
  logic [bba_pkg::StepW-1:0] steps;
  logic [bba_pkg::CntW-1:0]  init_i;
  logic [1:0]              st;

  logic [bba_pkg::CntW-1:0] region_n;
  logic [LvW-1:0]           req_lv;
  logic                     req_bad;
  logic [bba_pkg::CntW-1:0] size;
  logic [bba_pkg::CntW:0]   reach;
  logic [BlkW-1:0]          mate, bit_rlv, head_s, head_rlv;
  logic [BlkW-1:0]          rd_addr, wr_addr, wr_data;
  logic                     wr_en;
  logic [LvW-1:0]           s_dec;

  assign region_n = (total_blocks > bba_pkg::CntW'(bba_pkg::NumBlocks))
                  ? bba_pkg::CntW'(bba_pkg::NumBlocks) : total_blocks;

  always_comb begin
    req_lv = '0;
    for (int l = 0; l < bba_pkg::Levels; l++) begin
      if ((bba_pkg::CntW'(1) << l) < in_count) req_lv = req_lv + LvW'(1);
    end
  end

  assign size  = (req_lv < LvW'(bba_pkg::Levels)) ? (bba_pkg::CntW'(1) << req_lv) : '0;
  assign reach = {2'b00, in_index} + {1'b0, size};

  always_comb begin
    req_bad = 1'b0;
    if (in_count == '0 || req_lv >= LvW'(bba_pkg::Levels)) begin
      req_bad = 1'b1;
    end else if (in_op == bba_pkg::OP_FREE) begin
      if (in_index == '0 || (in_index & BlkW'(size - bba_pkg::CntW'(1))) != '0
          || reach > {1'b0, region_n})
        req_bad = 1'b1;
    end
  end

  assign bit_rlv  = BlkW'(1) << rlv;
  assign mate     = rb ^ bit_rlv;
  assign head_s   = (s < LvW'(bba_pkg::Levels)) ? head[s] : '0;
  assign head_rlv = (rlv < LvW'(bba_pkg::Levels)) ? head[rlv] : '0;
  assign s_dec    = s - LvW'(1);

  assign stat.init_done   = (init_i >= region_n);
  assign stat.bad         = (st == bba_pkg::ST_BAD);
  assign stat.op          = op;
  assign stat.s_over      = (s >= LvW'(bba_pkg::Levels));
  assign stat.head_s_zero = (head_s == '0);
  assign stat.s_gt_lv     = (s > lv);
  assign stat.rlv_top     = (rlv >= LvW'(bba_pkg::Levels - 1));
  assign stat.walk_end    = (cur == '0) || (steps >= bba_pkg::StepW'(bba_pkg::NumBlocks));
  assign stat.cur_hit     = (cur == mate);
  assign stat.out_busy    = out_valid && !out_ready;

  assign rd_addr = (ctl.cmd == bba_pkg::CMD_POP) ? head_s : cur;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = '0;
    case (ctl.cmd)
      bba_pkg::CMD_POP_WR: begin
        wr_en   = 1'b1;
        wr_addr = b;
      end
      bba_pkg::CMD_UNLINK: begin
        wr_en   = (prev != '0);
        wr_addr = prev;
        wr_data = rdata;
      end
      bba_pkg::CMD_CLR_CUR: begin
        wr_en   = 1'b1;
        wr_addr = cur;
      end
      bba_pkg::CMD_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = rb;
        wr_data = head_rlv;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= bba_pkg::CntW'(bba_pkg::NumBlocks);
    end else if (cfg_we) begin
      total_blocks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      bba_pkg::CMD_INIT_CLR: begin
        for (int l = 0; l < bba_pkg::Levels; l++) head[l] <= '0;
        init_i <= bba_pkg::CntW'(1);
      end
      bba_pkg::CMD_INIT_NEXT: begin
        rb     <= init_i[BlkW-1:0];
        rlv    <= '0;
        init_i <= init_i + bba_pkg::CntW'(1);
      end
      bba_pkg::CMD_LOAD: begin
        op <= in_op;
        lv <= req_lv;
        s  <= req_lv;
        rb <= in_index;
        st <= req_bad ? bba_pkg::ST_BAD : bba_pkg::ST_OK;
      end
      bba_pkg::CMD_FREE_SET: rlv <= lv;
      bba_pkg::CMD_SCAN:     s <= s + LvW'(1);
      bba_pkg::CMD_NOFREE:   st <= bba_pkg::ST_NO_FREE;
      bba_pkg::CMD_POP:      b <= head_s;
      bba_pkg::CMD_POP_WR:   head[s] <= rdata;
      bba_pkg::CMD_SPLIT: begin
        s   <= s_dec;
        rlv <= s_dec;
        rb  <= b + (BlkW'(1) << s_dec);
      end
      bba_pkg::CMD_REL_START: begin
        cur   <= head_rlv;
        prev  <= '0;
        steps <= '0;
      end
      bba_pkg::CMD_WALK_ADV: begin
        prev  <= cur;
        cur   <= rdata;
        steps <= steps + bba_pkg::StepW'(1);
      end
      bba_pkg::CMD_UNLINK: if (prev == '0) head[rlv] <= rdata;
      bba_pkg::CMD_CLR_CUR: begin
        rb  <= rb & ~bit_rlv;
        rlv <= rlv + LvW'(1);
      end
      bba_pkg::CMD_PUSH: head[rlv] <= rb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_status <= st;
      out_result <= (op == bba_pkg::OP_ALLOC && st == bba_pkg::ST_OK) ? b : '0;
    end
  end

endmodule
`default_nettype wire

### rtl/buddy_block_allocator_top.sv
// ---------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator over 256 blocks with an APB register for the region size.
// ---------------------------------------------------------------------------
// A rejected request goes straight to finish; otherwise the time grows with
// the work. An allocate takes longer for each level scanned and each split,
// and a free for each merge step and each free list link walked, since
// every link read goes through the single registered port of the link
// memory. A free at the top level is pushed without a buddy search. After
// reset and after each write of total_blocks the lists are rebuilt by
// freeing blocks 1 to n-1 in turn, and no word is accepted until the
// rebuild is done. The result word sits in an output register, but no new
// request is taken while a result waits for out_ready.
`default_nettype none
module buddy_block_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  block_index,
  input  wire logic [8:0]  block_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       result_index
);

  bba_pkg::ctl_t  ctl;
  bba_pkg::stat_t stat;
  logic           cfg_we;
  logic [8:0]     total_blocks;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, total_blocks} : 32'd0;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata[8:0]),
    .total_blocks (total_blocks),
    .in_op        (op),
    .in_index     (block_index),
    .in_count     (block_count),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (status),
    .out_result   (result_index)
  );

endmodule
`default_nettype wire
